// ===== hw/rtl/bba_pkg.sv =====
package bba_pkg;

	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int CFG_ADDR_W = 3;

	localparam logic             REG_BLOCK_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_SPACE     = 2'd1,
		ST_ALREADY_FREE = 2'd2,
		ST_OUT_OF_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FDIV,
		S_FREAD,
		S_FEVAL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic scan;
		logic fdiv;
		logic fread;
		logic feval;
		logic out_load;
	} bba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic count_zero;
		logic idx_in_range;
		logic scan_done;
		logic out_free;
	} bba_sts_t;

endpackage

// ===== hw/rtl/bba_req_if.sv =====
interface bba_req_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [IDX_W-1:0] block_index;

	modport source (output valid, operation, block_index, input ready);
	modport sink (input valid, operation, block_index, output ready);
endinterface

// ===== hw/rtl/bba_rsp_if.sv =====
interface bba_rsp_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] result_index;

	modport source (output valid, status, result_index, input ready);
	modport sink (input valid, status, result_index, output ready);
endinterface

// ===== hw/rtl/bba_ctrl.sv =====
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bba_pkg::bba_sts_t sts,
	output bba_pkg::bba_cmd_t cmd
);
	import bba_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (sts.op_free) begin
						state_d = sts.idx_in_range ? S_FDIV : S_DONE;
					end else begin
						state_d = sts.count_zero ? S_DONE : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.scan_done) state_d = S_DONE;
			end
			S_FDIV:  state_d = S_FREAD;
			S_FREAD: state_d = S_FEVAL;
			S_FEVAL: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clear = 1'b1;
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_SCAN:  cmd.scan  = 1'b1;
			S_FDIV:  cmd.fdiv  = 1'b1;
			S_FREAD: cmd.fread = 1'b1;
			S_FEVAL: cmd.feval = 1'b1;
			S_DONE:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hw/rtl/bba_dp.sv =====
module bba_dp #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bba_pkg::bba_cmd_t             cmd,
	output bba_pkg::bba_sts_t             sts,
	input  logic [bba_pkg::CNT_W-1:0]     eff_count,
	input  logic                          in_operation,
	input  logic [bba_pkg::IDX_W-1:0]     in_block_index,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [1:0]                    rsp_status,
	output logic [bba_pkg::IDX_W-1:0]     rsp_result_index
);
	import bba_pkg::*;

	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BW        = $clog2(WORD_BITS);
	localparam int BASE_W    = CNT_W + 1;
	// reciprocal of the word size, exact for any index below 2**CNT_W
	localparam int DIV_SH    = CNT_W + BW;
	localparam int RECIP     = (2**DIV_SH + WORD_BITS - 1) / WORD_BITS;
	localparam int RECIP_W   = DIV_SH + 1;
	localparam int PROD_W    = IDX_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_s1;
	logic [AW-1:0]        raddr;
	logic [AW-1:0]        waddr;
	logic                 re;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;

	logic [AW-1:0]        clr_ptr_q;
	logic [IDX_W-1:0]     req_idx_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [BASE_W-1:0]    rd_base_q;
	logic [AW-1:0]        ev_ptr_s1;
	logic [BASE_W-1:0]    ev_base_s1;
	logic                 ev_valid_s1;
	logic [AW-1:0]        fword_q;
	logic [BW-1:0]        fbit_q;
	status_t              res_status_q;
	logic [IDX_W-1:0]     res_index_q;
	logic                 out_valid_q;
	logic [1:0]           out_status_q;
	logic [IDX_W-1:0]     out_index_q;

	logic [BASE_W-1:0]    eff_ext;
	logic                 issue;
	logic [WORD_BITS-1:0] avail;
	logic                 found;
	logic [BW-1:0]        hit;
	logic                 ev_last;
	logic                 scan_hit;
	logic [BASE_W-1:0]    alloc_idx;
	logic [WORD_BITS-1:0] hit_mask;
	logic [PROD_W-1:0]    prod;
	logic [AW-1:0]        fword_d;
	logic [CNT_W-1:0]     fbase;
	logic [CNT_W-1:0]     foff;
	logic [WORD_BITS-1:0] fbit_mask;
	logic                 fbit_set;
	logic                 free_write;

	assign eff_ext = BASE_W'(eff_count);
	assign issue   = cmd.scan & (rd_base_q < eff_ext);

	// free bits of the word under evaluation, limited to the managed range
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			avail[j] = ~rdata_s1[j] & ((ev_base_s1 + BASE_W'(j)) < eff_ext);
		end
	end

	always_comb begin
		hit = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (avail[j]) hit = BW'(j);
		end
	end

	assign found     = |avail;
	assign ev_last   = (ev_base_s1 + BASE_W'(WORD_BITS)) >= eff_ext;
	assign scan_hit  = cmd.scan & ev_valid_s1 & found;
	assign alloc_idx = ev_base_s1 + BASE_W'(hit);
	assign hit_mask  = WORD_BITS'(1) << hit;

	assign prod      = PROD_W'(req_idx_q) * PROD_W'(RECIP_C);
	assign fword_d   = prod[DIV_SH +: AW];
	assign fbase     = CNT_W'(fword_q) * CNT_W'(WORD_BITS);
	assign foff      = CNT_W'(req_idx_q) - fbase;
	assign fbit_mask = WORD_BITS'(1) << fbit_q;
	assign fbit_set  = |(rdata_s1 & fbit_mask);
	assign free_write = cmd.feval & fbit_set;

	assign raddr = cmd.fread ? fword_q : rd_ptr_q;
	assign re    = issue | cmd.fread;

	always_comb begin
		we    = 1'b0;
		waddr = clr_ptr_q;
		wdata = '0;
		if (cmd.clear) begin
			we = 1'b1;
		end else if (scan_hit) begin
			we    = 1'b1;
			waddr = ev_ptr_s1;
			wdata = rdata_s1 | hit_mask;
		end else if (free_write) begin
			we    = 1'b1;
			waddr = fword_q;
			wdata = rdata_s1 & ~fbit_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q   <= '0;
			ev_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_ptr_q <= clr_ptr_q + AW'(1);
			ev_valid_s1 <= issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_idx_q <= in_block_index;
			rd_ptr_q  <= '0;
			rd_base_q <= '0;
			if (in_operation == OP_FREE) begin
				res_status_q <= sts.idx_in_range ? ST_OK : ST_OUT_OF_RANGE;
				res_index_q  <= in_block_index;
			end else begin
				res_status_q <= ST_NO_SPACE;
				res_index_q  <= '0;
			end
		end else begin
			if (issue) begin
				rd_ptr_q  <= rd_ptr_q + AW'(1);
				rd_base_q <= rd_base_q + BASE_W'(WORD_BITS);
			end
			if (scan_hit) begin
				res_status_q <= ST_OK;
				res_index_q  <= alloc_idx[IDX_W-1:0];
			end
			if (cmd.feval && !fbit_set) res_status_q <= ST_ALREADY_FREE;
		end
		if (issue) begin
			ev_ptr_s1  <= rd_ptr_q;
			ev_base_s1 <= rd_base_q;
		end
		if (cmd.fdiv) fword_q <= fword_d;
		if (cmd.fread) fbit_q <= foff[BW-1:0];
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
		end
	end

	assign sts.clr_last     = (clr_ptr_q == AW'(NUM_WORDS - 1));
	assign sts.op_free      = in_operation;
	assign sts.count_zero   = (eff_count == '0);
	assign sts.idx_in_range = ({1'b0, in_block_index} < eff_count);
	assign sts.scan_done    = ev_valid_s1 & (found | ev_last);
	assign sts.out_free     = ~out_valid_q | rsp_ready;

	assign rsp_valid        = out_valid_q;
	assign rsp_status       = out_status_q;
	assign rsp_result_index = out_index_q;

`ifndef SYNTHESIS
	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, scan_hit, free_write}))
		else $error("bitmap written by more than one source");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |-> (alloc_idx < eff_ext))
		else $error("allocated block at or above block count");

	a_free_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.feval |-> $past(cmd.fread))
		else $error("free evaluated without a preceding word read");
`endif

endmodule

// ===== hw/rtl/block_bitmap_allocator.sv =====
// First-fit bitmap block allocator.
// req channel carries operation (0 allocate, 1 free) and block_index; rsp channel
// returns status (0 ok, 1 no space, 2 already free, 3 out of range) and result_index.
// One request is processed at a time; a beat moves when valid and ready are both high.
// Allocate: the bitmap RAM is read one word per cycle from word 0, with the next
// word read while the previous is checked, until a word with a free block below
// the block count is found or the last word in range is checked; the single RAM
// read port sets this rate.
// Free: after accept the block steps through word index, read, update and load.
// An allocate with block count zero or a free out of range goes straight to load.
// After reset the RAM is cleared one word per cycle, all NUM_WORDS words (128 by
// default), with req ready held low; block_count resets to 4096 and may be written
// over APB at any time while idle.
// The result sits in an output register: while rsp is stalled the next request is
// still accepted and processed, and it waits only to hand over its own result.
module block_bitmap_allocator #(
	parameter int MAX_BLOCKS = 4096,
	parameter int WORD_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	bba_req_if.sink                            req,
	bba_rsp_if.source                          rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [bba_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import bba_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] eff_count;
	logic             reg_sel;
	bba_cmd_t         cmd;
	bba_sts_t         sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_BLOCK_COUNT);
	assign prdata  = reg_sel ? 32'(count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= BLOCK_COUNT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	// saturate to the bitmap size
	assign eff_count = (32'(count_q) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : count_q;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.eff_count        (eff_count),
		.in_operation     (req.operation),
		.in_block_index   (req.block_index),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_status       (rsp.status),
		.rsp_result_index (rsp.result_index)
	);

endmodule

// ===== test/tb_block_bitmap_allocator.sv =====
module tb_block_bitmap_allocator;
	import bba_pkg::*;

	localparam int NBLK = 4096;
	localparam logic [CFG_ADDR_W-1:0] BLOCK_COUNT_ADDR = CFG_ADDR_W'(4 * REG_BLOCK_COUNT);

	typedef enum logic {
		JOB_ITEM,
		JOB_CFG
	} job_kind_t;

	typedef struct {
		job_kind_t        kind;
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic [31:0]      value;
		logic             calm;
	} job_t;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] index;
	} reply_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bba_req_if req_bus ();
	bba_rsp_if rsp_bus ();

	block_bitmap_allocator #(
		.MAX_BLOCKS(NBLK),
		.WORD_BITS (32)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// allocator mirror
	logic             used_map [0:NBLK-1];
	logic [CNT_W-1:0] block_limit = BLOCK_COUNT_RST;
	reply_t           pending_replies [$];
	job_t             jobs [$];

	int   n_bad = 0;
	int   n_cfg = 0;
	int   n_granted = 0;
	int   n_full = 0;
	int   n_double = 0;
	int   n_range = 0;
	int   n_freed = 0;
	int   gap_left = 0;
	int   stall_left = 0;
	logic calm = 1'b0;
	logic [1:0] apb_step = 2'd0;

	function automatic reply_t allocator_outcome(input op_t op, input logic [IDX_W-1:0] idx);
		reply_t r;
		int     span;
		int     i;
		span = (block_limit > NBLK) ? NBLK : int'(block_limit);
		r.status = ST_OK;
		r.index = idx;
		if (op == OP_ALLOC) begin
			r.status = ST_NO_SPACE;
			r.index = '0;
			for (i = 0; i < span; i++) begin
				if (!used_map[i]) begin
					used_map[i] = 1'b1;
					r.status = ST_OK;
					r.index = IDX_W'(i);
					break;
				end
			end
		end else if (idx >= span) begin
			r.status = ST_OUT_OF_RANGE;
		end else if (!used_map[idx]) begin
			r.status = ST_ALREADY_FREE;
		end else begin
			used_map[idx] = 1'b0;
		end
		return r;
	endfunction

	task automatic add_item(input op_t op, input logic [IDX_W-1:0] idx);
		job_t j;
		j.kind = JOB_ITEM;
		j.op = op;
		j.idx = idx;
		j.value = '0;
		j.calm = 1'b0;
		jobs.push_back(j);
	endtask

	task automatic add_cfg(input logic [31:0] value, input logic quiet);
		job_t j;
		j.kind = JOB_CFG;
		j.op = OP_ALLOC;
		j.idx = '0;
		j.value = value;
		j.calm = quiet;
		jobs.push_back(j);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20000000;
		$display("%0t: run timed out, %0d replies outstanding", $time, pending_replies.size());
		$display("TB_ERROR");
		$finish;
	end

	// fill the job queue
	initial begin
		int ph;
		int k;
		int cnt;
		int span;
		int live;
		int p_alloc;
		int lim;

		// directed part, starting at the reset count
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_ALLOC, 12'hfff);
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_FREE, 12'd1);
		add_item(OP_FREE, 12'd1);
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_FREE, 12'hfff);
		add_item(OP_FREE, 12'd0);
		add_cfg(32'd0, 1'b0);
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_FREE, 12'd0);
		add_cfg(32'h1fff, 1'b0);
		add_item(OP_FREE, 12'hfff);
		add_item(OP_ALLOC, 12'd0);
		add_cfg(32'd3, 1'b0);
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_FREE, 12'd2);
		add_item(OP_FREE, 12'd3);
		add_item(OP_ALLOC, 12'd0);
		add_item(OP_ALLOC, 12'd0);
		// lower the count below live blocks, then raise it again
		add_cfg(32'd1, 1'b0);
		add_item(OP_FREE, 12'd2);
		add_item(OP_FREE, 12'd0);
		add_item(OP_ALLOC, 12'd0);
		add_cfg(32'd4097, 1'b0);
		add_item(OP_FREE, 12'd2);
		add_item(OP_FREE, 12'd2);
		add_item(OP_FREE, 12'd2048);

		for (ph = 0; ph < 16; ph++) begin
			if (ph == 0)
				cnt = NBLK;
			else if (ph % 4 == 3)
				case ($urandom_range(2))
					0: cnt = NBLK;
					1: cnt = 8191;
					default: cnt = $urandom_range(8191, NBLK + 1);
				endcase
			else if ($urandom_range(9) == 0)
				cnt = 0;
			else
				cnt = $urandom_range(160, 1);
			span = (cnt > NBLK) ? NBLK : cnt;
			add_cfg(32'(cnt), (ph >= 13) || ($urandom_range(4) == 0));
			live = 0;
			p_alloc = $urandom_range(75, 40);
			for (k = 0; k < 100; k++) begin
				if ($urandom_range(99) < p_alloc) begin
					add_item(OP_ALLOC, IDX_W'($urandom));
					if (live < span)
						live++;
				end else if (span == 0 || $urandom_range(9) == 0) begin
					add_item(OP_FREE, IDX_W'($urandom));
				end else begin
					// aim mostly at blocks that are likely held
					lim = (live + 2 < span) ? live + 2 : span;
					add_item(OP_FREE, IDX_W'($urandom_range(lim - 1)));
					if (live > 0)
						live--;
				end
			end
		end
	end

	// request side and register writes
	always @(posedge clk) begin
		job_t j;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.operation <= OP_ALLOC;
			req_bus.block_index <= '0;
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= '0;
			pwdata <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready && !calm && $urandom_range(3) == 0)
				gap_left = $urandom_range(3, 1);
			if (apb_step == 2'd1) begin
				penable <= 1'b1;
				apb_step <= 2'd2;
			end else if (apb_step == 2'd2) begin
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				apb_step <= 2'd0;
			end else if (req_bus.valid && !req_bus.ready) begin
				// hold the beat
			end else if (gap_left != 0) begin
				gap_left--;
				req_bus.valid <= 1'b0;
			end else if (jobs.size() == 0) begin
				req_bus.valid <= 1'b0;
			end else if (jobs[0].kind == JOB_CFG) begin
				req_bus.valid <= 1'b0;
				// write only once the block is idle and every reply is home
				if (!req_bus.valid && req_bus.ready && pending_replies.size() == 0) begin
					j = jobs.pop_front();
					psel <= 1'b1;
					penable <= 1'b0;
					pwrite <= 1'b1;
					paddr <= BLOCK_COUNT_ADDR;
					pwdata <= j.value;
					calm <= j.calm;
					apb_step <= 2'd1;
				end
			end else begin
				j = jobs.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.operation <= j.op;
				req_bus.block_index <= j.idx;
			end
		end
	end

	// mirror, reply check and response stalls
	always @(posedge clk) begin
		reply_t want;
		if (!arst_n) begin
			for (int k = 0; k < NBLK; k++)
				used_map[k] = 1'b0;
			rsp_bus.ready <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == BLOCK_COUNT_ADDR) begin
				block_limit = pwdata[CNT_W-1:0];
				n_cfg++;
			end
			if (req_bus.valid && req_bus.ready)
				pending_replies.push_back(
					allocator_outcome(op_t'(req_bus.operation), req_bus.block_index));
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_replies.size() == 0) begin
					n_bad++;
					$display("%0t: unexpected reply status %0d index %0d", $time,
						rsp_bus.status, rsp_bus.result_index);
				end else begin
					want = pending_replies.pop_front();
					if (rsp_bus.status !== want.status) begin
						n_bad++;
						$display("%0t: status expected %0d got %0d", $time,
							want.status, rsp_bus.status);
					end
					if (rsp_bus.result_index !== want.index) begin
						n_bad++;
						$display("%0t: result_index expected %0d got %0d", $time,
							want.index, rsp_bus.result_index);
					end
					case (want.status)
						ST_OK: if (want.index == rsp_bus.result_index) n_granted++;
						ST_NO_SPACE: n_full++;
						ST_ALREADY_FREE: n_double++;
						default: n_range++;
					endcase
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(5) == 0) begin
				stall_left = $urandom_range(2);
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n);
		do
			@(posedge clk);
		while (jobs.size() != 0 || req_bus.valid || pending_replies.size() != 0);
		// drain: no reply may trail the last one
		repeat (140) @(posedge clk);
		$display("replies checked: %0d ok, %0d no space, %0d double free, %0d out of range",
			n_granted, n_full, n_double, n_range);
		$display("block_count written %0d times, %0d mismatches", n_cfg, n_bad);
		if (n_bad == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
